### src/xalu_pkg.sv
// Shared types, operation codes and size helpers for the x86-style ALU.
`default_nettype none

package xalu_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 4;
  localparam int unsigned SIZE_W = 2;
  localparam int unsigned CNT_W  = 5;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_ADD = 4'd0;
  localparam logic [FUNC_W-1:0] FN_ADC = 4'd1;
  localparam logic [FUNC_W-1:0] FN_SUB = 4'd2;
  localparam logic [FUNC_W-1:0] FN_SBB = 4'd3;
  localparam logic [FUNC_W-1:0] FN_AND = 4'd4;
  localparam logic [FUNC_W-1:0] FN_OR  = 4'd5;
  localparam logic [FUNC_W-1:0] FN_XOR = 4'd6;
  localparam logic [FUNC_W-1:0] FN_SHL = 4'd7;
  localparam logic [FUNC_W-1:0] FN_SHR = 4'd8;

  // Operand size codes; any other code works at 32 bits.
  localparam logic [SIZE_W-1:0] SZ_8  = 2'd0;
  localparam logic [SIZE_W-1:0] SZ_16 = 2'd1;

  localparam logic [DATA_W-1:0] MASK_8  = 32'h0000_00ff;
  localparam logic [DATA_W-1:0] MASK_16 = 32'h0000_ffff;
  localparam logic [DATA_W-1:0] MASK_32 = 32'hffff_ffff;

  // The kept flag set.
  typedef struct packed {
    logic cf;
    logic pf;
    logic zf;
    logic sf;
    logic of;
  } flags_t;

  // One input item as held in the input register.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] src_operand;
    logic [DATA_W-1:0] dest_operand;
    logic [SIZE_W-1:0] size_code;
  } in_item_t;

  // Mask that keeps the bits of the operand size.
  function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] sz);
    logic [DATA_W-1:0] m;
    case (sz)
      SZ_8:    m = MASK_8;
      SZ_16:   m = MASK_16;
      default: m = MASK_32;
    endcase
    return m;
  endfunction

  // Sign bit of a value at the operand size.
  function automatic logic top_bit(input logic [DATA_W-1:0] v,
                                   input logic [SIZE_W-1:0] sz);
    logic b;
    case (sz)
      SZ_8:    b = v[7];
      SZ_16:   b = v[15];
      default: b = v[31];
    endcase
    return b;
  endfunction

  // Bit just above the operand size, i.e. the carry out of the top bit.
  function automatic logic carry_bit(input logic [DATA_W:0] v,
                                     input logic [SIZE_W-1:0] sz);
    logic b;
    case (sz)
      SZ_8:    b = v[8];
      SZ_16:   b = v[16];
      default: b = v[32];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### src/xalu_if.sv
// Valid/ready channel interfaces for the ALU's input and result items.
`default_nettype none

interface xalu_in_if;
  import xalu_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [DATA_W-1:0] src_operand;
  logic [DATA_W-1:0] dest_operand;
  logic [SIZE_W-1:0] size_code;

  modport source (output valid, func, src_operand, dest_operand, size_code,
                  input ready);
  modport sink   (input valid, func, src_operand, dest_operand, size_code,
                  output ready);
endinterface

interface xalu_out_if;
  import xalu_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_value;
  logic              carry_out;
  logic              parity_out;
  logic              zero_out;
  logic              sign_out;
  logic              overflow_out;

  modport source (output valid, result_value, carry_out, parity_out, zero_out,
                  sign_out, overflow_out,
                  input ready);
  modport sink   (input valid, result_value, carry_out, parity_out, zero_out,
                  sign_out, overflow_out,
                  output ready);
endinterface

`default_nettype wire

### src/xalu_exec.sv
// Combinational datapath: computes one item's result and its new flag set.
`default_nettype none

module xalu_exec (
  input  xalu_pkg::in_item_t            item,
  input  xalu_pkg::flags_t              flags_in,
  output logic [xalu_pkg::DATA_W-1:0]   result,
  output xalu_pkg::flags_t              flags_out
);
  import xalu_pkg::*;

  logic [DATA_W-1:0]   mask;
  logic [DATA_W-1:0]   s_m;
  logic [DATA_W-1:0]   d_m;
  logic [CNT_W-1:0]    count;
  logic                cin;
  logic [DATA_W:0]     sum;
  logic [DATA_W:0]     diff;
  logic [2*DATA_W-1:0] shl_w;
  logic                shl_cf;
  logic                upd_res;

  // Operands masked to the size, carry in, the shared adder and subtractor, and the left shifter.
  always_comb begin
    mask  = size_mask(item.size_code);
    s_m   = item.src_operand & mask;
    d_m   = item.dest_operand & mask;
    count = item.src_operand[CNT_W-1:0];
    cin   = flags_in.cf & ((item.func == FN_ADC) || (item.func == FN_SBB));
    sum   = {1'b0, s_m} + {1'b0, d_m} + {{DATA_W{1'b0}}, cin};
    diff  = {1'b0, d_m} - {1'b0, s_m} - {{DATA_W{1'b0}}, cin};
    shl_w = {{DATA_W{1'b0}}, d_m} << count;
    shl_cf = carry_bit(shl_w[DATA_W:0], item.size_code);
  end

  // Operation select and flag rules.
  always_comb begin
    flags_out = flags_in;
    result    = '0;
    upd_res   = 1'b1;
    case (item.func)
      FN_ADD, FN_ADC: begin
        result       = sum[DATA_W-1:0] & mask;
        flags_out.cf = carry_bit(sum, item.size_code);
        flags_out.of = top_bit(~(s_m ^ d_m) & (s_m ^ result), item.size_code);
      end
      FN_SUB, FN_SBB: begin
        result       = diff[DATA_W-1:0] & mask;
        flags_out.cf = diff[DATA_W];
        flags_out.of = top_bit((d_m ^ s_m) & (d_m ^ result), item.size_code);
      end
      FN_AND, FN_OR, FN_XOR: begin
        if (item.func == FN_AND) begin
          result = d_m & s_m;
        end else if (item.func == FN_OR) begin
          result = d_m | s_m;
        end else begin
          result = d_m ^ s_m;
        end
        flags_out.cf = 1'b0;
        flags_out.of = 1'b0;
      end
      FN_SHL: begin
        if (count == '0) begin
          result = d_m;
        end else begin
          result       = shl_w[DATA_W-1:0] & mask;
          flags_out.cf = shl_cf;
          if (count == CNT_W'(1)) begin
            flags_out.of = shl_cf ^ top_bit(result, item.size_code);
          end
        end
      end
      FN_SHR: begin
        if (count == '0) begin
          result = d_m;
        end else begin
          result       = d_m >> count;
          flags_out.cf = d_m[count - CNT_W'(1)];
          if (count == CNT_W'(1)) begin
            flags_out.of = top_bit(d_m, item.size_code);
          end
        end
      end
      default: begin
        upd_res = 1'b0;
      end
    endcase

    // Result flags from the sized result.
    if (upd_res) begin
      flags_out.pf = ~^result[7:0];
      flags_out.zf = (result == '0);
      flags_out.sf = top_bit(result, item.size_code);
    end
  end

endmodule

`default_nettype wire

### src/x86_alu_with_flags.sv
// Top level of the x86-style ALU: input register, datapath, result register, flags.
`default_nettype none

// x86-style integer ALU with kept CF, PF, ZF, SF and OF. An item is taken into
// an input register, evaluated by single-pass combinational logic and loaded
// into the result register together with the new flag set, so the block takes
// one item per cycle and a result appears the cycle after its item is taken
// when the output is not stalled. The flags written by one item are in the
// flag register by the time the next item is evaluated, so adc and sbb always
// see the carry of the item just before them. Each result item reports the
// sized result and all five flags as they stand after its operation; an
// unused operation code gives a zero result and the flags unchanged.

module x86_alu_with_flags (
  input  wire logic   clk,
  input  wire logic   rst_n,
  xalu_in_if.sink     in_ch,
  xalu_out_if.source  out_ch
);
  import xalu_pkg::*;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  in_item_t          s1_item_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] out_result_r;
  flags_t            flags_r;
  logic [DATA_W-1:0] exec_result;
  flags_t            exec_flags;
  logic              out_load;
  logic              in_fire;

  // Datapath for the item in the input register.
  xalu_exec u_exec (
    .item      (s1_item_r),
    .flags_in  (flags_r),
    .result    (exec_result),
    .flags_out (exec_flags)
  );

  // Handshake: the result register frees up when it is empty or being taken.
  assign out_load      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready   = !s1_valid_r || out_load;
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt  = in_fire || (s1_valid_r && !out_load);
  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (out_load) begin
        flags_r <= exec_flags;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.func         <= in_ch.func;
      s1_item_r.src_operand  <= in_ch.src_operand;
      s1_item_r.dest_operand <= in_ch.dest_operand;
      s1_item_r.size_code    <= in_ch.size_code;
    end
    if (out_load) begin
      out_result_r <= exec_result;
    end
  end

  // The flags of the item in the result register are the kept flags.
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_result_r;
  assign out_ch.carry_out    = flags_r.cf;
  assign out_ch.parity_out   = flags_r.pf;
  assign out_ch.zero_out     = flags_r.zf;
  assign out_ch.sign_out     = flags_r.sf;
  assign out_ch.overflow_out = flags_r.of;

  // Both stages come out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

  // The kept flags change only when an item moves into the result register.
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(flags_r))
    else $error("flags changed without an item completing");

  // Logic operations leave CF and OF clear.
  a_logic_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (s1_item_r.func == FN_AND || s1_item_r.func == FN_OR ||
                  s1_item_r.func == FN_XOR))
    |=> (!flags_r.cf && !flags_r.of))
    else $error("logic operation left CF or OF set");

  // An unused operation code gives zero and keeps every flag.
  a_unused_func: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (s1_item_r.func > FN_SHR))
    |=> ((out_result_r == '0) && $stable(flags_r)))
    else $error("unused operation code changed state");

endmodule

`default_nettype wire
